>>> sv/llpws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package llpws_pkg;

   localparam int NUM_CPUS_DEF  = 16;
   localparam int DEPTH_CAP_DEF = 255;
   localparam int MOVED_LIMIT   = 127;

   localparam int ACTION_W  = 2;
   localparam int CPU_ID_W  = 4;
   localparam int THREAD_W  = 16;
   localparam int STATUS_W  = 2;
   localparam int MOVED_W   = 7;
   localparam int ACTIVE_W  = 5;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam action_type ACT_ENQUEUE = 2'd0;
   localparam action_type ACT_STEAL   = 2'd1;
   localparam action_type ACT_DONE    = 2'd2;

   localparam status_type ST_OK         = 2'd0;
   localparam status_type ST_NO_VICTIM  = 2'd1;
   localparam status_type ST_ALL_FULL   = 2'd2;

endpackage

`default_nettype wire

>>> sv/least_loaded_placement_and_work_steal.sv
`timescale 1ns / 1ps
`default_nettype none

// Run-queue balancer: one depth counter per CPU held in a synchronous memory.
// Enqueue and steal read the depths of the effective active CPUs one per
// cycle; thread-done reads only the requester's depth, and a word that needs
// no memory access goes straight to the response state. A full output
// register holds the sequencer in that state. The single read port of the
// depth memory sets the scan rate. Reset clears all depths at once through
// per-entry valid bits, so no clearing pass follows reset. A finished word
// waits in the output register while the next request is taken.

module least_loaded_placement_and_work_steal
   import llpws_pkg::*;
#(
   parameter int NUM_CPUS  = NUM_CPUS_DEF,
   parameter int DEPTH_CAP = DEPTH_CAP_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic [ACTION_W-1:0] req_action,
   input  wire logic [CPU_ID_W-1:0] req_requester_cpu,
   input  wire logic [THREAD_W-1:0] req_thread_id,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic [STATUS_W-1:0] rsp_status,
   output      logic [CPU_ID_W-1:0] rsp_chosen_cpu,
   output      logic                rsp_kick,
   output      logic [MOVED_W-1:0]  rsp_moved_count,
   output      logic [THREAD_W-1:0] rsp_thread_echo,
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [ACTIVE_W-1:0] csr_active_cpus
);

   localparam int CPU_W = $clog2(NUM_CPUS);
   localparam int CNT_W = $clog2(NUM_CPUS + 1);
   localparam int DEP_W = $clog2(DEPTH_CAP + 1);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN     = 3'd1;
   localparam logic [2:0] S_DECIDE   = 3'd2;
   localparam logic [2:0] S_STEAL_WR = 3'd3;
   localparam logic [2:0] S_DONE_RD  = 3'd4;
   localparam logic [2:0] S_RESP     = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [ACTIVE_W-1:0] active_ff;

   logic [DEP_W-1:0]    depth_mem [NUM_CPUS];
   logic [NUM_CPUS-1:0] valid_ff;
   logic [DEP_W-1:0]    rd_data_ff;
   logic                rd_valid_ff;
   logic                rd_en, wr_en;
   logic [CPU_W-1:0]    rd_addr, wr_addr;
   logic [DEP_W-1:0]    wr_data;
   logic [DEP_W-1:0]    depth_rd;

   action_type          action_ff;
   logic [CPU_ID_W-1:0] req_cpu_ff;
   logic [THREAD_W-1:0] thread_ff;
   logic [CNT_W-1:0]    issue_ff;
   logic                pend_ff;
   logic [CPU_W-1:0]    pidx_ff;
   logic [CPU_W-1:0]    best_ff;
   logic [DEP_W-1:0]    sel_depth_ff;
   logic [DEP_W-1:0]    req_depth_ff;
   logic                found_ff;

   status_type          res_status_ff;
   logic [CPU_ID_W-1:0] res_chosen_ff;
   logic                res_kick_ff;
   logic [MOVED_W-1:0]  res_moved_ff;

   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic [CPU_ID_W-1:0] rsp_chosen_ff;
   logic                rsp_kick_ff;
   logic [MOVED_W-1:0]  rsp_moved_ff;
   logic [THREAD_W-1:0] rsp_thread_ff;

   logic [31:0]         act32, n32, half32;
   logic [CNT_W-1:0]    n_cnt;
   logic [MOVED_W-1:0]  take;
   logic                req_fire, scan_more, full, steal_ok, load_rsp;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      act32 = 32'(active_ff);
      if (act32 == 32'd0) begin
         n32 = 32'd1;
      end else if (act32 > 32'(NUM_CPUS)) begin
         n32 = 32'(NUM_CPUS);
      end else begin
         n32 = act32;
      end
      n_cnt = CNT_W'(n32);
   end

   assign depth_rd  = rd_valid_ff ? rd_data_ff : '0;
   assign scan_more = (issue_ff < n_cnt);
   assign full      = (32'(sel_depth_ff) >= 32'(DEPTH_CAP));
   assign steal_ok  = found_ff && (req_depth_ff == '0);
   assign half32    = 32'(sel_depth_ff) >> 1;
   assign take      = (half32 > 32'(MOVED_LIMIT)) ? MOVED_W'(MOVED_LIMIT) : MOVED_W'(half32);
   assign load_rsp  = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      rd_en    = 1'b0;
      rd_addr  = '0;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_action)
                  ACT_ENQUEUE: state_in = S_SCAN;
                  ACT_STEAL: begin
                     state_in = (32'(req_requester_cpu) >= n32) ? S_RESP : S_SCAN;
                  end
                  ACT_DONE: begin
                     if (32'(req_requester_cpu) < 32'(NUM_CPUS)) begin
                        rd_en    = 1'b1;
                        rd_addr  = CPU_W'(req_requester_cpu);
                        state_in = S_DONE_RD;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_SCAN: begin
            if (scan_more) begin
               rd_en   = 1'b1;
               rd_addr = issue_ff[CPU_W-1:0];
            end else if (!pend_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_RESP;
            if (action_ff == ACT_ENQUEUE) begin
               if (!full) begin
                  wr_en   = 1'b1;
                  wr_addr = best_ff;
                  wr_data = sel_depth_ff + DEP_W'(1);
               end
            end else if (steal_ok) begin
               wr_en    = 1'b1;
               wr_addr  = best_ff;
               wr_data  = sel_depth_ff - DEP_W'(take);
               state_in = S_STEAL_WR;
            end
         end
         S_STEAL_WR: begin
            wr_en    = 1'b1;
            wr_addr  = CPU_W'(req_cpu_ff);
            wr_data  = DEP_W'(take);
            state_in = S_RESP;
         end
         S_DONE_RD: begin
            if (depth_rd != '0) begin
               wr_en   = 1'b1;
               wr_addr = CPU_W'(req_cpu_ff);
               wr_data = depth_rd - DEP_W'(1);
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         depth_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= depth_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= ACTIVE_W'(1);
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         issue_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            active_ff <= csr_active_cpus;
         end
         pend_ff <= (state_ff == S_SCAN) && rd_en;
         if (req_fire) begin
            issue_ff <= '0;
            found_ff <= 1'b0;
         end else if ((state_ff == S_SCAN) && scan_more) begin
            issue_ff <= issue_ff + CNT_W'(1);
         end
         if (pend_ff && (action_ff == ACT_STEAL)
             && (32'(pidx_ff) != 32'(req_cpu_ff)) && (depth_rd > sel_depth_ff)) begin
            found_ff <= 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= rd_addr;
      if (req_fire) begin
         action_ff     <= req_action;
         req_cpu_ff    <= req_requester_cpu;
         thread_ff     <= req_thread_id;
         best_ff       <= '0;
         sel_depth_ff  <= DEP_W'(1);
         req_depth_ff  <= '0;
         res_status_ff <= ((req_action == ACT_STEAL) && (32'(req_requester_cpu) >= n32))
                          ? ST_NO_VICTIM : ST_OK;
         res_chosen_ff <= '0;
         res_kick_ff   <= 1'b0;
         res_moved_ff  <= '0;
      end
      if (pend_ff) begin
         if (action_ff == ACT_ENQUEUE) begin
            if ((pidx_ff == '0) || (depth_rd < sel_depth_ff)) begin
               sel_depth_ff <= depth_rd;
               best_ff      <= pidx_ff;
            end
         end else if (32'(pidx_ff) == 32'(req_cpu_ff)) begin
            req_depth_ff <= depth_rd;
         end else if (depth_rd > sel_depth_ff) begin
            sel_depth_ff <= depth_rd;
            best_ff      <= pidx_ff;
         end
      end
      if (state_ff == S_DECIDE) begin
         if (action_ff == ACT_ENQUEUE) begin
            if (full) begin
               res_status_ff <= ST_ALL_FULL;
            end else begin
               res_chosen_ff <= CPU_ID_W'(best_ff);
               res_kick_ff   <= (32'(best_ff) != 32'(req_cpu_ff));
            end
         end else if (steal_ok) begin
            res_chosen_ff <= CPU_ID_W'(best_ff);
            res_moved_ff  <= take;
         end else begin
            res_status_ff <= ST_NO_VICTIM;
         end
      end
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_chosen_ff <= res_chosen_ff;
         rsp_kick_ff   <= res_kick_ff;
         rsp_moved_ff  <= res_moved_ff;
         rsp_thread_ff <= thread_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_chosen_cpu  = rsp_chosen_ff;
   assign rsp_kick        = rsp_kick_ff;
   assign rsp_moved_count = rsp_moved_ff;
   assign rsp_thread_echo = rsp_thread_ff;

`ifndef NO_ASSERTIONS
   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && (state_ff == S_IDLE)))
      else $error("depth memory written while idle");

   a_no_read_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("depth memory read and written in the same cycle");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("request accepted but sequencer stayed idle");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_RESP))
      else $error("response raised outside the response state");

   a_fail_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_OK))
      |-> ((rsp_chosen_ff == '0) && (rsp_moved_ff == '0) && !rsp_kick_ff))
      else $error("failed response carries nonzero fields");
`endif

endmodule

`default_nettype wire
